// ===== hw/rtl/dctp_pkg.sv =====
// Package for the dithered chunky-to-planar unit.
// Holds the geometry constants, the word types and the dither slot function.
// No dependencies.
package dctp_pkg;

  localparam int unsigned SOURCE_ROWS    = 64;
  localparam int unsigned SOURCE_COLUMNS = 80;

  localparam int unsigned NumPixels  = 8;
  localparam int unsigned LevelWidth = 5;
  localparam int unsigned PlaneWidth = 16;
  localparam int unsigned AddrWidth  = 17;
  localparam int unsigned CountWidth = 8;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 9;

  localparam logic [CountWidth-1:0] WideLastCol =
      CountWidth'(SOURCE_COLUMNS / 4 - 1);
  localparam logic [CountWidth-1:0] NarrowLastCol =
      CountWidth'(SOURCE_COLUMNS / 8 - 1);
  localparam logic [CountWidth-1:0] LastRow = CountWidth'(SOURCE_ROWS - 1);

  localparam logic [6:0] LineWords    = 7'd80;
  localparam logic [8:0] WideStride   = 9'd320;
  localparam logic [8:0] NarrowStride = 9'd160;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_WIDE_MODE = 2'd0,
    CFG_BASE_LINE = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [LevelWidth-1:0] level0;
    logic [LevelWidth-1:0] level1;
    logic [LevelWidth-1:0] level2;
    logic [LevelWidth-1:0] level3;
    logic [LevelWidth-1:0] level4;
    logic [LevelWidth-1:0] level5;
    logic [LevelWidth-1:0] level6;
    logic [LevelWidth-1:0] level7;
  } pix_word_t;

  typedef struct packed {
    logic [AddrWidth-1:0]  word_address;
    logic [PlaneWidth-1:0] plane_bit0;
    logic [PlaneWidth-1:0] plane_bit1;
    logic [PlaneWidth-1:0] plane_bit2;
    logic [PlaneWidth-1:0] plane_bit3;
    logic                  row_end;
    logic                  frame_end;
  } plane_word_t;

  typedef struct packed {
    logic [CfgIdxWidth-1:0]  index;
    logic [CfgDataWidth-1:0] data;
  } cfg_word_t;

  // Returns {upper, lower} slot bits for bitplane p. Zero and odd levels fill
  // the slot with bit p of the halved level; even levels put bit p of h-1 in
  // the lower bits.
  function automatic logic [1:0] slot_pair(logic [LevelWidth-1:0] level, logic [1:0] p);
    logic [3:0] h;
    logic [3:0] hm;
    logic [1:0] res;
    h  = level[4:1];
    hm = h - 4'd1;
    if (level == '0 || level[0]) begin
      res = {h[p], h[p]};
    end else begin
      res = {h[p], hm[p]};
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/dctp_if.sv =====
// Handshake interfaces for the dithered chunky-to-planar unit.
// Depends on dctp_pkg for the word types.
interface dctp_pix_if;
  logic                 valid;
  logic                 ready;
  dctp_pkg::pix_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dctp_plane_if;
  logic                  valid;
  logic                  ready;
  dctp_pkg::plane_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dctp_cfg_if;
  logic                valid;
  logic                ready;
  dctp_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dithered_chunky_to_planar_unit.sv =====
// Top level of the dithered chunky-to-planar unit.
// Depends on dctp_pkg and the interfaces in dctp_if.sv.
//
//   channel  direction  word
//   pix_i    in         eight 5-bit shade levels
//   word_o   out        address, four bitplane words, row and frame end flags
//   cfg_i    in         register index and write data, always ready
//
// One word enters per cycle unless stalled, via the input and result registers.
// The column and row counters advance when a word is accepted, so the
// address path is two constant multiplies and adds between the input and result
// registers. A stalled result holds in the result register while one more
// word waits in the input register. Reset empties both stages, clears the
// counters and the base line, and selects wide mode.
module dithered_chunky_to_planar_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  dctp_pix_if.sink            pix_i,
  dctp_plane_if.source        word_o,
  dctp_cfg_if.sink            cfg_i
);

  logic                                wide_mode_q;
  logic [dctp_pkg::CfgDataWidth-1:0]   base_line_q;
  logic [dctp_pkg::CountWidth-1:0]     col_q, col_d;
  logic [dctp_pkg::CountWidth-1:0]     row_q, row_d;

  logic                                s1_valid_q;
  dctp_pkg::pix_word_t                 s1_pix_q;
  logic [dctp_pkg::CountWidth-1:0]     s1_col_q;
  logic [dctp_pkg::CountWidth-1:0]     s1_row_q;
  logic                                s1_rend_q;
  logic                                s1_fend_q;

  logic                                out_valid_q;
  dctp_pkg::plane_word_t               out_q, out_d;

  logic                                s2_ready;
  logic                                in_ready;
  logic                                in_fire;
  logic                                rend;
  logic                                fend;
  logic [dctp_pkg::CountWidth-1:0]     last_col;

  logic [dctp_pkg::LevelWidth-1:0]     levels [dctp_pkg::NumPixels];
  logic [dctp_pkg::PlaneWidth-1:0]     planes [4];
  logic [1:0]                          pair;

  assign s2_ready = !out_valid_q || word_o.ready;
  assign in_ready = !s1_valid_q || s2_ready;
  assign in_fire  = pix_i.valid && in_ready;

  assign pix_i.ready  = in_ready;
  assign cfg_i.ready  = 1'b1;
  assign word_o.valid = out_valid_q;
  assign word_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_mode_q <= 1'b1;
      base_line_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        dctp_pkg::CFG_WIDE_MODE: wide_mode_q <= cfg_i.data.data[0];
        dctp_pkg::CFG_BASE_LINE: base_line_q <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    last_col = wide_mode_q ? dctp_pkg::WideLastCol : dctp_pkg::NarrowLastCol;
    rend     = col_q >= last_col;
    fend     = rend && (row_q >= dctp_pkg::LastRow);
    col_d    = col_q;
    row_d    = row_q;
    if (in_fire) begin
      if (rend) begin
        col_d = '0;
        row_d = fend ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (in_ready) begin
        s1_valid_q <= pix_i.valid;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q  <= pix_i.data;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_rend_q <= rend;
      s1_fend_q <= fend;
    end
    if (s2_ready && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign levels[0] = s1_pix_q.level0;
  assign levels[1] = s1_pix_q.level1;
  assign levels[2] = s1_pix_q.level2;
  assign levels[3] = s1_pix_q.level3;
  assign levels[4] = s1_pix_q.level4;
  assign levels[5] = s1_pix_q.level5;
  assign levels[6] = s1_pix_q.level6;
  assign levels[7] = s1_pix_q.level7;

  // Pixel 0 lands at the most significant end of each plane word.
  always_comb begin
    pair = '0;
    for (int p = 0; p < 4; p++) begin
      planes[p] = '0;
      if (wide_mode_q) begin
        for (int i = 0; i < 4; i++) begin
          pair = dctp_pkg::slot_pair(levels[i], 2'(p));
          planes[p][15-4*i -: 4] = {pair, pair};
        end
      end else begin
        for (int i = 0; i < dctp_pkg::NumPixels; i++) begin
          pair = dctp_pkg::slot_pair(levels[i], 2'(p));
          planes[p][15-2*i -: 2] = pair;
        end
      end
    end
  end

  always_comb begin
    out_d.word_address =
        dctp_pkg::AddrWidth'(dctp_pkg::LineWords) * dctp_pkg::AddrWidth'(base_line_q) +
        dctp_pkg::AddrWidth'(s1_row_q) *
            dctp_pkg::AddrWidth'(wide_mode_q ? dctp_pkg::WideStride
                                             : dctp_pkg::NarrowStride) +
        dctp_pkg::AddrWidth'(s1_col_q);
    out_d.plane_bit0 = planes[0];
    out_d.plane_bit1 = planes[1];
    out_d.plane_bit2 = planes[2];
    out_d.plane_bit3 = planes[3];
    out_d.row_end    = s1_rend_q;
    out_d.frame_end  = s1_fend_q;
  end

endmodule

// ===== hw/rtl/dctp_checker.sv =====
// Port-level checker for the dithered chunky-to-planar unit.
// Depends on dctp_pkg; bound to dithered_chunky_to_planar_unit below.
module dctp_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  pix_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input dctp_pkg::plane_word_t out_data_i,
  input logic                  cfg_ready_i
);

  // A stalled result keeps its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result word changed or dropped");

  // The last word of a frame is also the last word of its row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && out_data_i.frame_end |-> out_data_i.row_end)
    else $error("frame end without row end");

  // With no result pending, the input side is never blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      !out_valid_i |-> pix_ready_i)
    else $error("input blocked while the result register is empty");

  // Configuration writes are always taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("configuration port not ready");

endmodule

bind dithered_chunky_to_planar_unit dctp_checker u_dctp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_ready_i (pix_i.ready),
  .out_valid_i (word_o.valid),
  .out_ready_i (word_o.ready),
  .out_data_i  (word_o.data),
  .cfg_ready_i (cfg_i.ready)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for dithered_chunky_to_planar_unit.
// Drives level words and register writes through the dctp_if interfaces and checks each
// plane word against a predictor of the dither, address and row/frame counters.
`timescale 1ns / 100ps

module testbench;

  localparam int ClkHalf = 5;
  localparam int ResetCycles = 4;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles = 10;
  localparam int PressureCycles = 64;
  localparam bit ModeWide = 1'b1;
  localparam bit ModeNarrow = 1'b0;
  localparam logic [dctp_pkg::CfgIdxWidth-1:0] CfgSpareIdxA = 2'd2;
  localparam logic [dctp_pkg::CfgIdxWidth-1:0] CfgSpareIdxB = 2'd3;

  typedef struct {
    dctp_pkg::pix_word_t   word;
    bit                    known;
    dctp_pkg::plane_word_t expect_word;
  } dir_row_t;

  typedef struct {
    bit         wide;
    logic [8:0] base;
    int         src_idle;
    int         sink_stall;
    int         hold;
    int         words;
    bit         spare;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dctp_pix_if   pix_if ();
  dctp_plane_if word_if ();
  dctp_cfg_if   cfg_if ();

  dithered_chunky_to_planar_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .word_o (word_if),
    .cfg_i  (cfg_if)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Predictor copy of the configuration and the counters.
  bit                    mode_wide = 1'b1;
  logic [8:0]            line_base = '0;
  logic [7:0]            col_pos = '0;
  logic [7:0]            row_pos = '0;
  dctp_pkg::plane_word_t planes_due[$];
  int                    error_count = 0;
  bit                    typed_known = 1'b0;
  dctp_pkg::plane_word_t typed_word = '0;
  int                    sink_stall_pct = 0;
  int                    hold_left = 0;
  int                    quiet_cycles = 0;

  dir_row_t dir_table [16] = '{
    '{'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0}, 1'b1,
      '{17'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0}},
    '{'{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31}, 1'b1,
      '{17'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0}},
    '{'{5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2}, 1'b1,
      '{17'd2, 16'hAAAA, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0}},
    '{'{5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1}, 1'b1,
      '{17'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0}},
    '{'{5'd0, 5'd0, 5'd0, 5'd0, 5'd31, 5'd31, 5'd31, 5'd31}, 1'b1,
      '{17'd4, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0}},
    '{'{5'd30, 5'd30, 5'd30, 5'd30, 5'd0, 5'd0, 5'd0, 5'd0}, 1'b0, '0},
    '{'{5'd4, 5'd6, 5'd8, 5'd10, 5'd1, 5'd2, 5'd3, 5'd4}, 1'b0, '0},
    '{'{5'd12, 5'd14, 5'd16, 5'd18, 5'd5, 5'd6, 5'd7, 5'd8}, 1'b0, '0},
    '{'{5'd20, 5'd22, 5'd24, 5'd26, 5'd9, 5'd10, 5'd11, 5'd12}, 1'b0, '0},
    '{'{5'd28, 5'd30, 5'd31, 5'd0, 5'd13, 5'd14, 5'd15, 5'd16}, 1'b0, '0},
    '{'{5'd3, 5'd5, 5'd7, 5'd9, 5'd17, 5'd18, 5'd19, 5'd20}, 1'b0, '0},
    '{'{5'd11, 5'd13, 5'd15, 5'd17, 5'd21, 5'd22, 5'd23, 5'd24}, 1'b0, '0},
    '{'{5'd19, 5'd21, 5'd23, 5'd25, 5'd25, 5'd26, 5'd27, 5'd28}, 1'b0, '0},
    '{'{5'd27, 5'd29, 5'd1, 5'd2, 5'd31, 5'd30, 5'd16, 5'd8}, 1'b0, '0},
    '{'{5'd16, 5'd16, 5'd16, 5'd16, 5'd5, 5'd5, 5'd5, 5'd5}, 1'b1,
      '{17'd14, 16'h5555, 16'h5555, 16'h5555, 16'hAAAA, 1'b0, 1'b0}},
    '{'{5'd31, 5'd0, 5'd31, 5'd0, 5'd31, 5'd31, 5'd31, 5'd31}, 1'b1,
      '{17'd15, 16'hF0F0, 16'hF0F0, 16'hF0F0, 16'hF0F0, 1'b0, 1'b0}}
  };

  // The first narrow phase starts with the column count past the narrow row length.
  phase_t phases [5] = '{
    '{ModeNarrow, 9'd511, 0, 0, 0, 280, 1'b0},
    '{ModeWide, 9'd510, 47, 0, 0, 280, 1'b0},
    '{ModeNarrow, 9'd0, 0, 47, PressureCycles, 280, 1'b1},
    '{ModeWide, 9'd255, 14, 14, 0, 280, 1'b0},
    '{ModeNarrow, 9'd137, 0, 0, 0, 240, 1'b0}
  };

  function automatic logic [3:0] dither_slot(logic [4:0] level, int plane, bit wide);
    logic [3:0] half;
    logic [3:0] half_less;
    logic [3:0] slot;
    half = level[4:1];
    half_less = half - 4'd1;
    if (level == 5'd0 || level[0]) begin
      slot = half[plane] ? (wide ? 4'hF : 4'h3) : 4'h0;
    end else begin
      slot = (half[plane] ? (wide ? 4'hA : 4'h2) : 4'h0)
           | (half_less[plane] ? (wide ? 4'h5 : 4'h1) : 4'h0);
    end
    return slot;
  endfunction

  function automatic dctp_pkg::plane_word_t convert_word(dctp_pkg::pix_word_t w, bit wide,
                                                         logic [8:0] base,
                                                         logic [7:0] col, logic [7:0] row);
    logic [4:0]            levels [8];
    logic [15:0]           acc;
    dctp_pkg::plane_word_t res;
    int                    npix;
    int                    stride;
    int                    last_col;
    int                    addr;
    levels = '{w.level0, w.level1, w.level2, w.level3,
               w.level4, w.level5, w.level6, w.level7};
    npix = wide ? 4 : 8;
    stride = wide ? int'(dctp_pkg::WideStride) : int'(dctp_pkg::NarrowStride);
    last_col = wide ? int'(dctp_pkg::SOURCE_COLUMNS / 4 - 1)
                    : int'(dctp_pkg::SOURCE_COLUMNS / 8 - 1);
    for (int p = 0; p < 4; p++) begin
      acc = '0;
      for (int i = 0; i < npix; i++) begin
        acc = (acc << (wide ? 4 : 2)) | 16'(dither_slot(levels[i], p, wide));
      end
      case (p)
        0: res.plane_bit0 = acc;
        1: res.plane_bit1 = acc;
        2: res.plane_bit2 = acc;
        default: res.plane_bit3 = acc;
      endcase
    end
    addr = int'(dctp_pkg::LineWords) * int'(base) + int'(row) * stride + int'(col);
    res.word_address = addr[dctp_pkg::AddrWidth-1:0];
    res.row_end = int'(col) >= last_col;
    res.frame_end = res.row_end && (int'(row) >= int'(dctp_pkg::SOURCE_ROWS) - 1);
    return res;
  endfunction

  function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    dctp_pkg::plane_word_t due;
    dctp_pkg::plane_word_t got;
    dctp_pkg::plane_word_t pred;
    if (word_if.valid && word_if.ready) begin
      got = word_if.data;
      if (planes_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word, expected none, actual %p", $time, got);
      end else begin
        due = planes_due.pop_front();
        check_field("word_address", due.word_address, got.word_address);
        check_field("plane_bit0", 17'(due.plane_bit0), 17'(got.plane_bit0));
        check_field("plane_bit1", 17'(due.plane_bit1), 17'(got.plane_bit1));
        check_field("plane_bit2", 17'(due.plane_bit2), 17'(got.plane_bit2));
        check_field("plane_bit3", 17'(due.plane_bit3), 17'(got.plane_bit3));
        check_field("row_end", 17'(due.row_end), 17'(got.row_end));
        check_field("frame_end", 17'(due.frame_end), 17'(got.frame_end));
      end
    end
    if (cfg_if.valid && cfg_if.ready) begin
      if (cfg_if.data.index == dctp_pkg::CFG_WIDE_MODE) begin
        mode_wide = cfg_if.data.data[0];
      end else if (cfg_if.data.index == dctp_pkg::CFG_BASE_LINE) begin
        line_base = cfg_if.data.data;
      end
    end
    if (pix_if.valid && pix_if.ready) begin
      pred = convert_word(pix_if.data, mode_wide, line_base, col_pos, row_pos);
      if (pred.row_end) begin
        col_pos = '0;
        row_pos = pred.frame_end ? 8'd0 : row_pos + 8'd1;
      end else begin
        col_pos = col_pos + 8'd1;
      end
      planes_due.push_back(typed_known ? typed_word : pred);
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      word_if.ready <= 1'b0;
      hold_left--;
    end else begin
      word_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (word_if.valid && word_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_word(dctp_pkg::pix_word_t w, bit known, dctp_pkg::plane_word_t want,
                           int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.data <= w;
    typed_known = known;
    typed_word = want;
    do @(posedge clk_i); while (!(pix_if.valid && pix_if.ready));
    @(negedge clk_i);
  endtask

  task automatic program_regs(phase_t ph);
    dctp_pkg::cfg_word_t writes[$];
    writes.push_back('{index: dctp_pkg::CFG_WIDE_MODE, data: 9'(ph.wide)});
    writes.push_back('{index: dctp_pkg::CFG_BASE_LINE, data: ph.base});
    if (ph.spare) begin
      writes.push_back('{index: CfgSpareIdxA, data: 9'h1FF});
      writes.push_back('{index: CfgSpareIdxB, data: 9'(~ph.base)});
    end
    foreach (writes[i]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.data <= writes[i];
      do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
      @(negedge clk_i);
    end
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    dctp_pkg::pix_word_t w;
    logic [39:0]         bits;
    pix_if.valid = 1'b0;
    pix_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_table[i]) begin
      send_word(dir_table[i].word, dir_table[i].known, dir_table[i].expect_word, 0);
    end
    pix_if.valid <= 1'b0;

    foreach (phases[k]) begin
      while (planes_due.size() != 0) @(negedge clk_i);
      sink_stall_pct = 0;
      program_regs(phases[k]);
      sink_stall_pct = phases[k].sink_stall;
      hold_left = phases[k].hold;
      for (int n = 0; n < phases[k].words; n++) begin
        bits[31:0] = $urandom();
        bits[39:32] = 8'($urandom_range(0, 255));
        w = bits;
        send_word(w, 1'b0, '0, phases[k].src_idle);
      end
      pix_if.valid <= 1'b0;
    end

    while (planes_due.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dctp_pkg.sv
hw/rtl/dctp_if.sv
hw/rtl/dithered_chunky_to_planar_unit.sv
hw/rtl/dctp_checker.sv
tb/testbench.sv
